@@ design/assert_macros.svh @@
// Assertion macros for the Bloom filter RTL, used by the back end.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge out of reset.
`define BFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define BFM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/bfm_pkg.sv @@
// Shared constants, types and helper functions of the Bloom filter block.
// Used by every module of the design but bfm_ram; depends on nothing else.
package bfm_pkg;

    localparam int MAX_BITS    = 65536;
    localparam int ADDR_W      = $clog2(MAX_BITS);
    localparam int N_W         = ADDR_W + 1;
    localparam int MIN_BITS    = 64;
    localparam int PROBE_LIMIT = 16;
    localparam int K_W         = 5;
    localparam int DIV_TOP     = 64;
    localparam int DIV_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] MIX_M    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] M_LO     = MIX_M[31:0];
    localparam logic [31:0] M_HI     = MIX_M[63:32];
    localparam int          MIX_R    = 47;
    localparam logic [63:0] SEED_ONE = 64'h0000_0000_9747_b28c;
    localparam logic [63:0] SEED_TWO = 64'h0000_0000_c6a4_a793;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_BIT_COUNT  = 1'b0;
    localparam logic REG_HASH_COUNT = 1'b1;

    typedef struct packed {
        logic [63:0] h1;
        logic [63:0] h2;
        logic        op;
    } hash_item_t;

    function automatic logic [63:0] fold(input logic [63:0] x);
        return x ^ (x >> MIX_R);
    endfunction

    function automatic logic [63:0] tail_mask(input logic [3:0] nb);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < nb) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] mod_step(input logic [ADDR_W-1:0] r,
                                                   input logic b,
                                                   input logic [N_W-1:0] n);
        logic [N_W-1:0] t;
        t = {r, b};
        return (t >= n) ? ADDR_W'(t - n) : ADDR_W'(t);
    endfunction

endpackage

@@ design/bfm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module bfm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bfm_front.sv @@
// Front end: accepts key words and runs both MurmurHash64A accumulators.
// Uses bfm_pkg; hands finished hash pairs to the queue.
module bfm_front import bfm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        enable,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [63:0] s_key_word,
    input  logic [3:0]  s_word_bytes,
    input  logic        s_last_word,
    input  logic [12:0] s_key_length,
    output logic        q_push,
    output hash_item_t  q_item,
    input  logic        q_full
);

    typedef enum logic [8:0] {
        F_IDLE = 9'b000000001,
        F_PREP = 9'b000000010,
        F_MK1  = 9'b000000100,
        F_MK2  = 9'b000001000,
        F_MH1  = 9'b000010000,
        F_MH2  = 9'b000100000,
        F_FH1  = 9'b001000000,
        F_FH2  = 9'b010000000,
        F_PUSH = 9'b100000000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [1:0]  ph_reg, ph_next;
    logic        prog_reg, prog_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] k_reg, k_next;
    logic        op_reg, op_next;
    logic [3:0]  nb_reg, nb_next;
    logic        last_reg, last_next;
    logic [12:0] klen_reg, klen_next;

    logic [63:0] x_op, prod, mul_res, seed_mix, base1, base2, tail;
    logic [31:0] mul_a, mul_b, hi_p;
    logic [44:0] lo_p;
    logic        mul_done;

    assign s_ready  = (state_reg == F_IDLE) && enable;
    assign q_item   = '{h1: h1_reg, h2: h2_reg, op: op_reg};

    assign x_op     = (state_reg == F_MK1 || state_reg == F_MK2) ? k_reg :
                      (state_reg == F_MH1 || state_reg == F_FH1) ? h1_reg : h2_reg;
    assign mul_a    = (ph_reg == 2'd1) ? x_op[63:32] : x_op[31:0];
    assign mul_b    = (ph_reg == 2'd2) ? M_HI : M_LO;
    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign mul_res  = acc_reg + {prod[31:0], 32'b0};
    assign mul_done = (ph_reg == 2'd2);

    assign lo_p     = 45'(klen_reg) * 45'(M_LO);
    assign hi_p     = 32'(klen_reg) * M_HI;
    assign seed_mix = {hi_p, 32'b0} + 64'(lo_p);
    assign base1    = prog_reg ? h1_reg : (SEED_ONE ^ seed_mix);
    assign base2    = prog_reg ? h2_reg : (SEED_TWO ^ seed_mix);
    assign tail     = k_reg & tail_mask(nb_reg);

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        prog_next  = prog_reg;
        acc_next   = acc_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        nb_next    = nb_reg;
        last_next  = last_reg;
        klen_next  = klen_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    k_next     = s_key_word;
                    op_next    = s_operation;
                    nb_next    = s_word_bytes;
                    last_next  = s_last_word;
                    klen_next  = s_key_length;
                    state_next = F_PREP;
                end
            end
            F_PREP: begin
                prog_next = !last_reg;
                if (nb_reg[3]) begin
                    h1_next    = base1;
                    h2_next    = base2;
                    state_next = F_MK1;
                end else if (nb_reg != 4'd0) begin
                    h1_next    = base1 ^ tail;
                    h2_next    = base2 ^ tail;
                    state_next = F_MH1;
                end else if (last_reg) begin
                    h1_next    = fold(base1);
                    h2_next    = fold(base2);
                    state_next = F_FH1;
                end else begin
                    h1_next    = base1;
                    h2_next    = base2;
                    state_next = F_IDLE;
                end
            end
            F_MK1, F_MK2, F_MH1, F_MH2, F_FH1, F_FH2: begin
                ph_next  = ph_reg + 2'd1;
                acc_next = (ph_reg == 2'd0) ? prod : mul_res;
                if (mul_done) begin
                    ph_next = 2'd0;
                    priority if (state_reg == F_MK1) begin
                        k_next     = fold(mul_res);
                        state_next = F_MK2;
                    end else if (state_reg == F_MK2) begin
                        h1_next    = h1_reg ^ mul_res;
                        h2_next    = h2_reg ^ mul_res;
                        state_next = F_MH1;
                    end else if (state_reg == F_MH1) begin
                        h1_next    = mul_res;
                        state_next = F_MH2;
                    end else if (state_reg == F_MH2) begin
                        if (last_reg) begin
                            h1_next    = fold(h1_reg);
                            h2_next    = fold(mul_res);
                            state_next = F_FH1;
                        end else begin
                            h2_next    = mul_res;
                            state_next = F_IDLE;
                        end
                    end else if (state_reg == F_FH1) begin
                        h1_next    = fold(mul_res);
                        state_next = F_FH2;
                    end else begin
                        h2_next    = fold(mul_res);
                        state_next = F_PUSH;
                    end
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            ph_reg    <= 2'd0;
            prog_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            prog_reg  <= prog_next;
        end
        acc_reg  <= acc_next;
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        k_reg    <= k_next;
        op_reg   <= op_next;
        nb_reg   <= nb_next;
        last_reg <= last_next;
        klen_reg <= klen_next;
    end

endmodule

@@ design/bfm_fifo.sv @@
// Short queue of finished hash pairs between the front and back ends.
// Uses bfm_pkg for the entry type and depth.
module bfm_fifo import bfm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  hash_item_t push_item,
    output logic       full,
    input  logic       pop,
    output hash_item_t pop_item,
    output logic       empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hash_item_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

@@ design/bfm_back.sv @@
// Back end: reduces hash pairs modulo the bit count, probes the bit store
// and holds the query result. Uses bfm_pkg, bfm_ram and assert_macros.svh.
`include "assert_macros.svh"
module bfm_back import bfm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [16:0] bit_count,
    input  logic [4:0]  hash_count,
    input  logic        q_empty,
    input  hash_item_t  q_item,
    output logic        q_pop,
    output logic        clear_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_maybe_present
);

    typedef enum logic [5:0] {
        B_CLEAR = 6'b000001,
        B_IDLE  = 6'b000010,
        B_DIV   = 6'b000100,
        B_PROBE = 6'b001000,
        B_CHECK = 6'b010000,
        B_OUT   = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [63:0]       v_reg, v_next, h2_reg, h2_next;
    logic              op_reg, op_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [K_W-1:0]    kc_reg, kc_next, i_reg, i_next;
    logic [DIV_W-1:0]  bit_reg, bit_next;
    logic [ADDR_W-1:0] r1_reg, r1_next, r2_reg, r2_next, r64_reg, r64_next;
    logic              all_reg, all_next, pend_reg, pend_next;
    logic              mv_reg, mv_next, mp_reg, mp_next;

    logic              hb1, hb2, carry, ram_we, ram_wd, rdata;
    logic [ADDR_W-1:0] ram_wa, s1, step;
    logic [N_W-1:0]    s_sum, fix;
    logic [64:0]       v_sum;

    assign clear_busy      = (state_reg == B_CLEAR);
    assign m_valid         = mv_reg;
    assign m_maybe_present = mp_reg;

    assign hb1   = bit_reg[DIV_W-1] ? 1'b0 : v_reg[bit_reg[5:0]];
    assign hb2   = bit_reg[DIV_W-1] ? 1'b0 : h2_reg[bit_reg[5:0]];

    assign s_sum = {1'b0, r1_reg} + {1'b0, r2_reg};
    assign s1    = (s_sum >= n_reg) ? ADDR_W'(s_sum - n_reg) : ADDR_W'(s_sum);
    assign v_sum = {1'b0, v_reg} + {1'b0, h2_reg};
    assign carry = v_sum[64];
    assign fix   = {1'b0, s1} + n_reg - {1'b0, r64_reg};
    assign step  = !carry ? s1 : (s1 >= r64_reg) ? (s1 - r64_reg) : ADDR_W'(fix);

    assign ram_we = clear_busy || (state_reg == B_PROBE && op_reg == OP_ADD);
    assign ram_wa = clear_busy ? clr_reg : r1_reg;
    assign ram_wd = !clear_busy;

    bfm_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (r1_reg),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        v_next     = v_reg;
        h2_next    = h2_reg;
        op_next    = op_reg;
        n_next     = n_reg;
        kc_next    = kc_reg;
        i_next     = i_reg;
        bit_next   = bit_reg;
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        r64_next   = r64_reg;
        all_next   = (pend_reg && !rdata) ? 1'b0 : all_reg;
        pend_next  = 1'b0;
        mv_next    = (mv_reg && m_ready) ? 1'b0 : mv_reg;
        mp_next    = mp_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            B_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    v_next   = q_item.h1;
                    h2_next  = q_item.h2;
                    op_next  = q_item.op;
                    if (32'(bit_count) < MIN_BITS) begin
                        n_next = N_W'(MIN_BITS);
                    end else if (32'(bit_count) > MAX_BITS) begin
                        n_next = N_W'(MAX_BITS);
                    end else begin
                        n_next = N_W'(bit_count);
                    end
                    if (hash_count == '0) begin
                        kc_next = K_W'(1);
                    end else if (32'(hash_count) > PROBE_LIMIT) begin
                        kc_next = K_W'(PROBE_LIMIT);
                    end else begin
                        kc_next = hash_count;
                    end
                    bit_next   = DIV_W'(DIV_TOP);
                    r1_next    = '0;
                    r2_next    = '0;
                    r64_next   = '0;
                    i_next     = '0;
                    all_next   = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                r1_next  = mod_step(r1_reg, hb1, n_reg);
                r2_next  = mod_step(r2_reg, hb2, n_reg);
                r64_next = mod_step(r64_reg, bit_reg[DIV_W-1], n_reg);
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    state_next = B_PROBE;
                end
            end
            B_PROBE: begin
                pend_next = (op_reg == OP_QUERY);
                r1_next   = step;
                v_next    = v_sum[63:0];
                i_next    = i_reg + 1'b1;
                if (i_reg == kc_reg - 1'b1) begin
                    state_next = (op_reg == OP_QUERY) ? B_CHECK : B_IDLE;
                end
            end
            B_CHECK: state_next = B_OUT;
            B_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mp_next    = all_reg;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
        v_reg   <= v_next;
        h2_reg  <= h2_next;
        op_reg  <= op_next;
        n_reg   <= n_next;
        kc_reg  <= kc_next;
        i_reg   <= i_next;
        bit_reg <= bit_next;
        r1_reg  <= r1_next;
        r2_reg  <= r2_next;
        r64_reg <= r64_next;
        all_reg <= all_next;
        mp_reg  <= mp_next;
    end

    `BFM_ASSERT(a_probe_in_range, (state_reg != B_PROBE) || ({1'b0, r1_reg} < n_reg), "probe index not below bit count")
    `BFM_ASSERT(a_rem_in_range, (state_reg != B_DIV) || ({1'b0, r2_reg} < n_reg && {1'b0, r64_reg} < n_reg), "remainder not below bit count")
    `BFM_ASSERT_NEXT(a_clear_ends, state_reg == B_CLEAR && clr_reg == '1, state_reg == B_IDLE, "clearing pass did not end")

endmodule

@@ design/bloom_filter_membership.sv @@
// Top level of the Bloom filter membership block with its register port.
// Uses bfm_pkg, bfm_front, bfm_fifo and bfm_back.
//
// Keys enter as 64-bit words on the s_ channel (valid/ready), with the key
// length, the add or query operation and a last-word mark. A query gives one
// word on the m_ channel; adds and non-last words give none.
// A full word runs four 64-bit multiplies in the hash front end, each built
// from partial products on one 32x32 multiplier; a partial word runs two and
// an empty word none. A last word adds two multiplies for finalizing and the
// queue push. The back end then takes the pair, runs the bit-serial reduction
// modulo the bit count and probes the bit store once per hash; a query passes
// a check state and an output state before its result is valid. A two-entry
// queue lets the front hash the next key while the back probes.
// After reset the bit store is cleared one bit a cycle, all 65536 bits, while
// s_ready stays low; register writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the back end
// then waits, the queue fills and s_ready eventually drops.
// Registers: bit_count at address 0, hash_count at address 4.
module bloom_filter_membership import bfm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [63:0] s_key_word,
    input  logic [3:0]  s_word_bytes,
    input  logic        s_last_word,
    input  logic [12:0] s_key_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_maybe_present,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [16:0] bit_count_reg;
    logic [4:0]  hash_count_reg;
    logic        clear_busy, q_push, q_full, q_pop, q_empty;
    hash_item_t  push_item, pop_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HASH_COUNT) ? {27'b0, hash_count_reg}
                                                 : {15'b0, bit_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg  <= 17'd1024;
            hash_count_reg <= 5'd7;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_BIT_COUNT) begin
                bit_count_reg <= pwdata[16:0];
            end else begin
                hash_count_reg <= pwdata[4:0];
            end
        end
    end

    bfm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (!clear_busy),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_key_word   (s_key_word),
        .s_word_bytes (s_word_bytes),
        .s_last_word  (s_last_word),
        .s_key_length (s_key_length),
        .q_push       (q_push),
        .q_item       (push_item),
        .q_full       (q_full)
    );

    bfm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    bfm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .bit_count       (bit_count_reg),
        .hash_count      (hash_count_reg),
        .q_empty         (q_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .clear_busy      (clear_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_maybe_present (m_maybe_present)
    );

endmodule
